>>> rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Field widths, operation codes, the table entry layout and the command and
// status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package pps_pkg;

   // Default table depth.
   localparam int MAX_PROCS_DEF = 16;

   // Field widths.
   localparam int OP_W    = 2;
   localparam int PID_W   = 16;
   localparam int TIME_W  = 32;
   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;

   // Request operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // One process entry as held in the table.
   typedef struct packed {
      logic [PID_W-1:0]   pid;
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] remaining;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
   } entry_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic clear;
      logic scan_start;
      logic scan_step;
      logic scan_eval;
      logic update;
      logic times;
      logic result;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic count_zero;
      logic scan_last;
      logic rsp_free;
   } sts_type;

endpackage

>>> rtl/pps_if.sv
// ----------------------------------------------------------------------------
// Scheduler channel interfaces
// Request and response channels, each with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface pps_req_if;
   logic                         valid;
   logic                         ready;
   logic [pps_pkg::OP_W-1:0]     operation;
   logic [pps_pkg::PID_W-1:0]    proc_id;
   logic [pps_pkg::TIME_W-1:0]   arrive_at;
   logic [pps_pkg::BURST_W-1:0]  burst_len;
   logic [pps_pkg::PRIO_W-1:0]   prio;

   modport source (output valid, operation, proc_id, arrive_at, burst_len, prio,
                   input ready);
   modport sink   (input valid, operation, proc_id, arrive_at, burst_len, prio,
                   output ready);
endinterface

interface pps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         ran;
   logic [pps_pkg::PID_W-1:0]    run_pid;
   logic [pps_pkg::TIME_W-1:0]   slot_end;
   logic                         finished;
   logic [pps_pkg::TIME_W-1:0]   turnaround;
   logic [pps_pkg::TIME_W-1:0]   waiting;
   logic                         all_done;

   modport source (output valid, ran, run_pid, slot_end, finished, turnaround,
                   waiting, all_done,
                   input ready);
   modport sink   (input valid, ran, run_pid, slot_end, finished, turnaround,
                   waiting, all_done,
                   output ready);
endinterface

>>> rtl/pps_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Accepts request transactions and sequences the table scan, the update of
// the chosen entry and the loading of the response register.
// ----------------------------------------------------------------------------
module pps_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [pps_pkg::OP_W-1:0] req_op,
   output logic                     req_ready,
   input  pps_pkg::sts_type         sts,
   output pps_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      UPDATE,
      TIMES,
      RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Requests are taken only between ticks.
   assign req_ready = (state_ff == IDLE);

   // Next state and command decode.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               case (pps_pkg::op_type'(req_op))
                  pps_pkg::OP_LOAD: begin
                     cmd.load = 1'b1;
                  end
                  pps_pkg::OP_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  pps_pkg::OP_TICK: begin
                     cmd.scan_start = 1'b1;
                     state_in = sts.count_zero ? UPDATE : SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         SCAN: begin
            // One table entry is judged each cycle.
            cmd.scan_eval = 1'b1;
            if (sts.scan_last) begin
               state_in = UPDATE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         UPDATE: begin
            cmd.update = 1'b1;
            state_in   = TIMES;
         end
         TIMES: begin
            cmd.times = 1'b1;
            state_in  = RESULT;
         end
         RESULT: begin
            // Wait for the response register to be free.
            if (sts.rsp_free) begin
               cmd.result = 1'b1;
               state_in   = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/pps_datapath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Process table memory, best-candidate registers, time and entry count, and
// the response register.
// ----------------------------------------------------------------------------
module pps_datapath #(
   parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pps_pkg::cmd_type               cmd,
   output pps_pkg::sts_type               sts,
   input  logic [pps_pkg::PID_W-1:0]      ld_pid,
   input  logic [pps_pkg::TIME_W-1:0]     ld_arrival,
   input  logic [pps_pkg::BURST_W-1:0]    ld_burst,
   input  logic [pps_pkg::PRIO_W-1:0]     ld_prio,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_ran,
   output logic [pps_pkg::PID_W-1:0]      rsp_pid,
   output logic [pps_pkg::TIME_W-1:0]     rsp_slot_end,
   output logic                           rsp_finished,
   output logic [pps_pkg::TIME_W-1:0]     rsp_turnaround,
   output logic [pps_pkg::TIME_W-1:0]     rsp_waiting,
   output logic                           rsp_all_done
);

   localparam int IW = $clog2(MAX_PROCS);
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam int TW = pps_pkg::TIME_W;

   // Process table.
   pps_pkg::entry_type entry_mem_ff [MAX_PROCS];
   pps_pkg::entry_type rd_data_ff;
   logic [IW-1:0]      rd_addr;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   pps_pkg::entry_type wr_data;

   // Control and working registers.
   logic [CW-1:0]      count_ff, count_in;
   logic [TW-1:0]      time_ff, time_in;
   logic [IW-1:0]      scan_addr_ff, scan_addr_in;
   pps_pkg::entry_type best_ff, best_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic               found_ff, found_in;
   logic [1:0]         work_ff, work_in;
   logic               fin_ff, fin_in;
   logic [TW-1:0]      tat_ff, tat_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ran_ff, rsp_ran_in;
   logic [pps_pkg::PID_W-1:0] rsp_pid_ff, rsp_pid_in;
   logic [TW-1:0]      rsp_slot_end_ff, rsp_slot_end_in;
   logic               rsp_fin_ff, rsp_fin_in;
   logic [TW-1:0]      rsp_tat_ff, rsp_tat_in;
   logic [TW-1:0]      rsp_wait_ff, rsp_wait_in;
   logic               rsp_done_ff, rsp_done_in;

   logic               table_full;
   logic               eligible;
   logic               better;

   assign table_full = (count_ff == CW'(MAX_PROCS));

   // Scan read address: next entry while stepping, else the first.
   assign rd_addr = cmd.scan_step ? (scan_addr_ff + IW'(1)) : '0;

   // An entry competes once it has arrived and still has work.
   assign eligible = (rd_data_ff.remaining != '0) && (rd_data_ff.arrival <= time_ff);
   assign better   = eligible &&
                     (!found_ff ||
                      (rd_data_ff.prio < best_ff.prio) ||
                      ((rd_data_ff.prio == best_ff.prio) &&
                       (rd_data_ff.arrival < best_ff.arrival)));

   // Table write: a load appends, an update retires one unit of work.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = best_ff;
      wr_data.remaining = best_ff.remaining - pps_pkg::BURST_W'(1);
      if (cmd.load && !table_full) begin
         wr_en             = 1'b1;
         wr_addr           = count_ff[IW-1:0];
         wr_data.pid       = ld_pid;
         wr_data.arrival   = ld_arrival;
         wr_data.remaining = ld_burst;
         wr_data.burst     = ld_burst;
         wr_data.prio      = ld_prio;
      end else if (cmd.update && found_ff) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   // Next values of the working registers.
   always_comb begin
      count_in     = count_ff;
      time_in      = time_ff;
      scan_addr_in = scan_addr_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      found_in     = found_ff;
      work_in      = work_ff;
      fin_in       = fin_ff;
      tat_in       = tat_ff;

      if (cmd.clear) begin
         count_in = '0;
         time_in  = '0;
      end
      if (cmd.load && !table_full) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.scan_start) begin
         scan_addr_in = '0;
         found_in     = 1'b0;
         work_in      = 2'd0;
      end
      if (cmd.scan_step) begin
         scan_addr_in = rd_addr;
      end
      if (cmd.scan_eval) begin
         if (better) begin
            best_in     = rd_data_ff;
            best_idx_in = scan_addr_ff;
            found_in    = 1'b1;
         end
         // Entries with work left, counted up to two.
         if ((rd_data_ff.remaining != '0) && (work_ff != 2'd2)) begin
            work_in = work_ff + 2'd1;
         end
      end
      if (cmd.update) begin
         time_in = time_ff + TW'(1);
         fin_in  = found_ff && (best_ff.remaining == pps_pkg::BURST_W'(1));
      end
      if (cmd.times) begin
         // Time has already advanced to the end of the slot here.
         tat_in = time_ff - best_ff.arrival;
      end
   end

   // Next values of the response register.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_ran_in      = rsp_ran_ff;
      rsp_pid_in      = rsp_pid_ff;
      rsp_slot_end_in = rsp_slot_end_ff;
      rsp_fin_in      = rsp_fin_ff;
      rsp_tat_in      = rsp_tat_ff;
      rsp_wait_in     = rsp_wait_ff;
      rsp_done_in     = rsp_done_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.result) begin
         rsp_valid_in    = 1'b1;
         rsp_ran_in      = found_ff;
         rsp_pid_in      = found_ff ? best_ff.pid : '0;
         rsp_slot_end_in = time_ff;
         rsp_fin_in      = fin_ff;
         rsp_tat_in      = fin_ff ? tat_ff : '0;
         rsp_wait_in     = fin_ff ? (tat_ff - TW'(best_ff.burst)) : '0;
         rsp_done_in     = (work_ff == 2'd0) || ((work_ff == 2'd1) && fin_ff);
      end
   end

   // Registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_addr_ff    <= scan_addr_in;
      best_ff         <= best_in;
      best_idx_ff     <= best_idx_in;
      found_ff        <= found_in;
      work_ff         <= work_in;
      fin_ff          <= fin_in;
      tat_ff          <= tat_in;
      rsp_ran_ff      <= rsp_ran_in;
      rsp_pid_ff      <= rsp_pid_in;
      rsp_slot_end_ff <= rsp_slot_end_in;
      rsp_fin_ff      <= rsp_fin_in;
      rsp_tat_ff      <= rsp_tat_in;
      rsp_wait_ff     <= rsp_wait_in;
      rsp_done_ff     <= rsp_done_in;
   end

   // Status to the controller.
   assign sts.count_zero = (count_ff == '0);
   assign sts.scan_last  = ((CW'(scan_addr_ff) + CW'(1)) == count_ff);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ran        = rsp_ran_ff;
   assign rsp_pid        = rsp_pid_ff;
   assign rsp_slot_end   = rsp_slot_end_ff;
   assign rsp_finished   = rsp_fin_ff;
   assign rsp_turnaround = rsp_tat_ff;
   assign rsp_waiting    = rsp_wait_ff;
   assign rsp_all_done   = rsp_done_ff;

endmodule

>>> rtl/preemptive_priority_scheduler.sv
// Load and clear transactions complete as they are accepted, staying idle.
// A tick's response is registered after the scan, update, times and result
// states (the scan is skipped with an empty table); the scan reads one
// table entry per cycle through the single memory read port.
// A tick blocks requests until its response is loaded into a free register.
// Reset zeroes the entry count and time and empties the response register.
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Holds a table of process entries and, on each tick, runs the arrived entry
// with the lowest priority value for one time unit and reports the slot.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
   parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
   input logic     clock,
   input logic     reset,
   pps_req_if.sink   req,
   pps_rsp_if.source rsp
);

   pps_pkg::cmd_type cmd;
   pps_pkg::sts_type sts;

   // Sequencing.
   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_op    (req.operation),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Table, selection and response.
   pps_datapath #(
      .MAX_PROCS (MAX_PROCS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .ld_pid         (req.proc_id),
      .ld_arrival     (req.arrive_at),
      .ld_burst       (req.burst_len),
      .ld_prio        (req.prio),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .rsp_ran        (rsp.ran),
      .rsp_pid        (rsp.run_pid),
      .rsp_slot_end   (rsp.slot_end),
      .rsp_finished   (rsp.finished),
      .rsp_turnaround (rsp.turnaround),
      .rsp_waiting    (rsp.waiting),
      .rsp_all_done   (rsp.all_done)
   );

   // The controller issues at most one datapath command per cycle, scan_eval apart.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.clear, cmd.scan_start, cmd.scan_step,
                cmd.update, cmd.times, cmd.result}))
      else $error("more than one datapath command in a cycle");

   // A completion can only be reported for a slot in which an entry ran.
   a_finish_needs_run: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.finished |-> rsp.ran)
      else $error("completion reported in an idle slot");

   // An idle slot carries zero pid and zero times.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ran |-> (rsp.run_pid == '0) && (rsp.turnaround == '0) &&
                                (rsp.waiting == '0))
      else $error("idle slot with non-zero payload");

   // A tick transaction keeps the request side closed in the next cycle.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && (req.operation == pps_pkg::OP_TICK) |=> !req.ready)
      else $error("request accepted while a tick is in progress");

endmodule
